### rtl/core/ipv4dd_pkg.sv
// Package for the dotted-decimal IPv4 checker.
// Holds character codes, parser limits and the result struct; no dependencies.
package ipv4dd_pkg;

	localparam int MAX_TEXT_DEF = 64;

	localparam int CH_W           = 8;
	localparam int DOT_W          = 2;
	localparam int LEN_W          = 2;
	localparam int VAL_W          = 10;
	localparam int OUT_TDATA_W    = 8;

	localparam logic [CH_W-1:0]  CH_NUL  = 8'h00;
	localparam logic [CH_W-1:0]  CH_DOT  = 8'h2E;
	localparam logic [CH_W-1:0]  CH_ZERO = 8'h30;
	localparam logic [CH_W-1:0]  CH_NINE = 8'h39;

	localparam logic [DOT_W-1:0] MAX_DOTS       = 2'd3;
	localparam logic [LEN_W-1:0] MAX_DIGITS     = 2'd3;
	localparam logic [VAL_W-1:0] MAX_PART_VALUE = 10'd255;

	typedef struct packed {
		logic too_long;
		logic valid_res;
	} res_t;

endpackage

### rtl/core/ipv4dd_parse.sv
// Input register stage and byte parser of the dotted-decimal IPv4 checker.
// Depends on ipv4dd_pkg; drives one result word per terminating zero byte.
module ipv4dd_parse import ipv4dd_pkg::*; #(
	parameter int MAX_TEXT = MAX_TEXT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [CH_W-1:0] s_tdata,
	input  logic            room,
	output logic            res_valid,
	output res_t            res
);

	localparam int CNT_W = $clog2(MAX_TEXT);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TEXT - 1);

	logic [CH_W-1:0]  ch_s1;
	logic             vld_s1;
	logic             take;

	logic [DOT_W-1:0] dot_q, dot_d;
	logic [LEN_W-1:0] plen_q, plen_d;
	logic [VAL_W-1:0] pval_q, pval_d;
	logic             lead0_q, lead0_d;
	logic             bad_q, bad_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             ovf_q, ovf_d;

	logic             is_digit;
	logic [VAL_W-1:0] pval_x10;

	assign take     = vld_s1 && (ch_s1 != CH_NUL || room);
	assign s_tready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			ch_s1 <= s_tdata;
		end
	end

	assign is_digit = ch_s1 >= CH_ZERO && ch_s1 <= CH_NINE;
	assign pval_x10 = {pval_q[VAL_W-4:0], 3'b000} + {pval_q[VAL_W-2:0], 1'b0};

	always_comb begin
		dot_d   = dot_q;
		plen_d  = plen_q;
		pval_d  = pval_q;
		lead0_d = lead0_q;
		bad_d   = bad_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		if (ch_s1 == CH_NUL) begin
			dot_d   = '0;
			plen_d  = '0;
			pval_d  = '0;
			lead0_d = 1'b0;
			bad_d   = 1'b0;
			cnt_d   = '0;
			ovf_d   = 1'b0;
		end else if (ovf_q) begin
			ovf_d = 1'b1;
		end else if (cnt_q == CNT_LAST) begin
			ovf_d = 1'b1;
		end else begin
			cnt_d = cnt_q + 1'b1;
			if (ch_s1 == CH_DOT) begin
				if (plen_q == '0 || pval_q > MAX_PART_VALUE || dot_q == MAX_DOTS) begin
					bad_d = 1'b1;
				end
				if (dot_q != MAX_DOTS) begin
					dot_d = dot_q + 1'b1;
				end
				plen_d  = '0;
				pval_d  = '0;
				lead0_d = 1'b0;
			end else if (is_digit) begin
				if (plen_q == MAX_DIGITS || (plen_q == LEN_W'(1) && lead0_q)) begin
					bad_d = 1'b1;
				end else begin
					if (plen_q == '0) begin
						lead0_d = ch_s1 == CH_ZERO;
					end
					pval_d = pval_x10 + VAL_W'(ch_s1[3:0]);
					plen_d = plen_q + 1'b1;
				end
			end else begin
				bad_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q   <= '0;
			plen_q  <= '0;
			pval_q  <= '0;
			lead0_q <= 1'b0;
			bad_q   <= 1'b0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			dot_q   <= dot_d;
			plen_q  <= plen_d;
			pval_q  <= pval_d;
			lead0_q <= lead0_d;
			bad_q   <= bad_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
		end
	end

	assign res_valid     = take && ch_s1 == CH_NUL;
	assign res.too_long  = ovf_q;
	assign res.valid_res = !ovf_q && !bad_q && cnt_q != '0 && dot_q == MAX_DOTS
		&& plen_q != '0 && pval_q <= MAX_PART_VALUE;

	a_clear_after_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> cnt_q == '0 && !ovf_q && !bad_q && dot_q == '0)
		else $error("parser state not cleared after result");

	a_ovf_count: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> cnt_q == CNT_LAST)
		else $error("overflow without full count");

	a_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		lead0_q |-> pval_q == '0 && plen_q == LEN_W'(1))
		else $error("leading zero part extended");

	a_part_value: assert property (@(posedge clk) disable iff (!arst_n)
		pval_q < VAL_W'(1000))
		else $error("part value out of three-digit range");

endmodule

### rtl/core/ipv4dd_out.sv
// Result register of the dotted-decimal IPv4 checker.
// Depends on ipv4dd_pkg; holds one result word until the sink takes it.
module ipv4dd_out import ipv4dd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   res_valid,
	input  res_t                   res,
	output logic                   room,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic vld_q;
	res_t res_q;

	assign room = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (room) begin
			vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (room && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {{(OUT_TDATA_W-2){1'b0}}, res_q.too_long, res_q.valid_res};

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && vld_q && !m_tready))
		else $error("result word dropped");

	a_long_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && res_q.too_long |-> !res_q.valid_res)
		else $error("too-long text reported valid");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !m_tready |=> vld_q && $stable(res_q))
		else $error("stalled result word changed");

endmodule

### rtl/core/ipv4_dotted_decimal_check.sv
// Dotted-decimal IPv4 checker: one text byte per input word, one result per zero byte.
// A zero byte passes through the input register and then the result register, whose
// valid flag drives m_axis_tvalid toward the sink.
// Throughput: one byte per cycle; a zero byte waits in the input register only while the
// result register holds a word that the sink does not take in that cycle.
// Reset: arst_n clears the parser state and the input and result valid flags.
module ipv4_dotted_decimal_check import ipv4dd_pkg::*; #(
	parameter int MAX_TEXT = MAX_TEXT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [CH_W-1:0]        s_axis_tdata,   // [7:0] ch
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [0] valid_res, [1] too_long, [7:2] zero
);

	logic room;
	logic res_valid;
	res_t res;

	ipv4dd_parse #(
		.MAX_TEXT(MAX_TEXT)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.room     (room),
		.res_valid(res_valid),
		.res      (res)
	);

	ipv4dd_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res      (res),
		.room     (room),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata)
	);

endmodule

### test/ipv4_dotted_decimal_check_test.sv
// Testbench for ipv4_dotted_decimal_check: streams address text byte by byte and
// checks each result word against a scoreboard that parses the same bytes.
// Depends on ipv4dd_pkg and the ipv4_dotted_decimal_check RTL.
module ipv4_dotted_decimal_check_test;
	import ipv4dd_pkg::*;

	localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES = 300;

	class ipv4_scoreboard;
		logic [DOT_W-1:0] dots;
		logic [LEN_W-1:0] digits;
		logic [VAL_W-1:0] value;
		logic lead_zero;
		logic broken;
		logic [6:0] length;
		logic overflow;
		res_t verdicts[$];
		int errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			dots = '0;
			digits = '0;
			value = '0;
			lead_zero = 1'b0;
			broken = 1'b0;
			length = '0;
			overflow = 1'b0;
		endfunction

		function int pending();
			return verdicts.size();
		endfunction

		function void parse_char(logic [CH_W-1:0] ch);
			if (ch == CH_DOT) begin
				if (digits == 0 || value > MAX_PART_VALUE)
					broken = 1'b1;
				if (dots == MAX_DOTS)
					broken = 1'b1;
				else
					dots = dots + 1'b1;
				digits = '0;
				value = '0;
				lead_zero = 1'b0;
			end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
				if (digits == MAX_DIGITS) begin
					broken = 1'b1;
				end else if (digits == 1 && lead_zero) begin
					broken = 1'b1;
				end else begin
					if (digits == 0)
						lead_zero = (ch == CH_ZERO);
					value = VAL_W'(value * 10 + VAL_W'(ch - CH_ZERO));
					digits = digits + 1'b1;
				end
			end else begin
				broken = 1'b1;
			end
		endfunction

		function void note_byte(logic [CH_W-1:0] ch);
			res_t r;
			if (ch == CH_NUL) begin
				r.valid_res = !(overflow || broken || length == 0 || dots != MAX_DOTS
					|| digits == 0 || value > MAX_PART_VALUE);
				r.too_long = overflow;
				verdicts.push_back(r);
				clear();
			end else if (!overflow) begin
				if (length >= MAX_TEXT_DEF - 1) begin
					overflow = 1'b1;
				end else begin
					length = length + 1'b1;
					parse_char(ch);
				end
			end
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task check_word(logic [OUT_TDATA_W-1:0] word);
			res_t want;
			if (verdicts.size() == 0) begin
				report($sformatf("result word %h with no string pending", word));
			end else begin
				want = verdicts.pop_front();
				if (word[0] !== want.valid_res)
					report($sformatf("valid_res %b, expected %b", word[0], want.valid_res));
				if (word[1] !== want.too_long)
					report($sformatf("too_long %b, expected %b", word[1], want.too_long));
				if (word[OUT_TDATA_W-1:2] !== '0)
					report($sformatf("pad bits %b not zero", word[OUT_TDATA_W-1:2]));
			end
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [CH_W-1:0] s_axis_tdata = '0;	// [7:0] ch
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;	// [0] valid_res, [1] too_long, [7:2] zero

	ipv4_scoreboard sb;
	logic [CH_W-1:0] text_q[$];
	int src_idle = 17;
	int sink_idle = 70;
	int sent = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	ipv4_dotted_decimal_check DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * LIMIT_CYCLES);
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: random stalls, or a long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_byte(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata);
	end

	task send_word(logic [CH_W-1:0] ch);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task send_text();
		foreach (text_q[i])
			send_word(text_q[i]);
		send_word(CH_NUL);
		text_q.delete();
	endtask

	task push_str(string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	function logic [CH_W-1:0] digit_or_dot();
		return ($urandom_range(3) == 0) ? CH_DOT : CH_ZERO + CH_W'($urandom_range(9));
	endfunction

	task gen_address();
		int nparts;
		int pick;
		nparts = 4;
		pick = $urandom_range(99);
		if (pick < 8)
			nparts = 3;
		else if (pick < 16)
			nparts = 5;
		for (int p = 0; p < nparts; p++) begin
			if (p > 0)
				push_str(".");
			pick = $urandom_range(99);
			if (pick < 60) begin
				push_str($sformatf("%0d", $urandom_range(255)));
			end else if (pick < 75) begin
				case ($urandom_range(5))
					0: push_str("0");
					1: push_str("255");
					2: push_str("256");
					3: push_str("9");
					4: push_str("10");
					default: push_str("100");
				endcase
			end else if (pick < 83) begin
				push_str($sformatf("%0d", $urandom_range(999, 256)));
			end else if (pick < 90) begin
				push_str($sformatf("0%0d", $urandom_range(99)));
			end else if (pick < 95) begin
				push_str($sformatf("%0d", $urandom_range(9999, 1000)));
			end
		end
		if ($urandom_range(99) < 12)
			text_q.insert($urandom_range(text_q.size()),
				$urandom_range(1) ? CH_COLON : CH_W'($urandom_range(255, 1)));
	endtask

	task gen_noise();
		int n;
		int pick;
		n = $urandom_range(20);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(9);
			if (pick < 4)
				text_q.push_back(CH_W'($urandom_range(255, 1)));
			else if (pick < 9)
				text_q.push_back(digit_or_dot());
			else
				text_q.push_back(CH_COLON);
		end
	endtask

	task gen_overlong();
		int n;
		n = $urandom_range(75, 61);
		for (int i = 0; i < n; i++)
			text_q.push_back(digit_or_dot());
	endtask

	task run_phase(int src, int sink, int count, bit squeeze);
		int stop;
		int pick;
		src_idle = src;
		sink_idle = sink;
		stop = sent + count;
		if (squeeze)
			hold_req = 1'b1;
		while (sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 70)
				gen_address();
			else if (pick < 90)
				gen_noise();
			else if (pick < 95)
				gen_overlong();
			send_text();
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		string directed[$];
		sb = new();
		directed = '{"", "0.0.0.0", "255.255.255.255", "256.1.1.1", "1.2.3", "1.2.3.4.5",
			".1.2.3", "1.2.3.", "1..2.3", "1234.1.1.1", "01.1.1.1", "10.0.0.1", "1:2.3.4",
			"a.b.c.d", "199.99.9.0"};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			push_str(directed[i]);
			send_text();
		end
		run_phase(17, 70, 400, 1'b0);
		run_phase(70, 17, 400, 1'b0);
		run_phase(0, 0, 400, 1'b1);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
